[src/tcpt_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Triangle centroid polygon test package
// Shared sizes, function codes, sequencer states and the coordinate helpers.
// ---------------------------------------------------------------------------
package tcpt_pkg;

	localparam int MAX_EDGES  = 64;
	localparam int COORD_BITS = 16;

	localparam int IN_W    = 16;
	localparam int FUNC_W  = 2;
	localparam int TOTAL_W = 7;

	localparam int ADDR_W  = $clog2(MAX_EDGES);
	localparam int FILL_W  = $clog2(MAX_EDGES + 1);
	localparam int ENTRY_W = 4 * COORD_BITS;

	// Sum of three corners, and a coordinate scaled by three.
	localparam int SUM_W  = COORD_BITS + 2;
	// Centroid minus a scaled corner, and the span of one edge.
	localparam int DIFF_W = COORD_BITS + 3;
	localparam int SPAN_W = COORD_BITS + 1;
	localparam int PROD_W = DIFF_W + SPAN_W;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TEST   = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [SPAN_W-1:0]     span_t;
	typedef logic signed [PROD_W-1:0]     prod_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_PREP,
		ST_MULA,
		ST_MULB,
		ST_FINISH
	} state_t;

	// Low COORD_BITS of a port value, sign-extended.
	function automatic coord_t take_coord(input logic [IN_W-1:0] raw);
		return coord_t'(signed'(raw));
	endfunction

	function automatic sum_t times3(input coord_t c);
		return (sum_t'(c) <<< 1) + sum_t'(c);
	endfunction

endpackage
`default_nettype wire

[src/tcpt_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module tcpt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[src/triangle_centroid_polygon_test.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Triangle centroid polygon test
// Even-odd ray test of a triangle centroid against a table of polygon edges.
// ---------------------------------------------------------------------------
// A clear, an append or an unused code is taken while idle: its result
// shows on done in the next cycle and busy stays low, so such transactions
// can be issued back to back. A test keeps busy high while it scans the
// stored edges, then raises done with its result once the scan is over;
// each edge passes through edge memory read, operand set-up, and
// two passes through the single shared multiplier. The receiver cannot
// stall: each result is valid only in the cycle that done is high.
module triangle_centroid_polygon_test (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [tcpt_pkg::FUNC_W-1:0]     func,
	input  wire logic signed [tcpt_pkg::IN_W-1:0] ax,
	input  wire logic signed [tcpt_pkg::IN_W-1:0] ay,
	input  wire logic signed [tcpt_pkg::IN_W-1:0] bx,
	input  wire logic signed [tcpt_pkg::IN_W-1:0] by,
	input  wire logic signed [tcpt_pkg::IN_W-1:0] cx,
	input  wire logic signed [tcpt_pkg::IN_W-1:0] cy,
	output logic                                 done,
	output logic                                 inside_res,
	output logic                                 table_full,
	output logic [tcpt_pkg::TOTAL_W-1:0]         edge_total
);

	import tcpt_pkg::*;

	state_t state_q, state_d;

	logic              accept;
	logic              room;
	logic              last_edge;
	logic              mul_rhs;
	logic              toggle;
	logic              odd_d;

	logic [FILL_W-1:0] fill_q;
	logic [ADDR_W-1:0] idx_q;
	logic              odd_q;
	logic              cmp_pend_q;
	logic              done_q, inside_q, full_q;

	sum_t              sx_q, sy_q;
	logic [ENTRY_W-1:0] rd_data;
	coord_t            e_x0, e_y0, e_x1, e_y1;
	sum_t              xi3, yi3, xj3, yj3;
	logic              straddle, left_of;

	diff_t             opa_q, opc_q;
	span_t             opb_q, opd_q;
	logic              hit_q, dpos_q;
	diff_t             mul_a;
	span_t             mul_b;
	prod_t             product;
	prod_t             lhs_q, rhs_q;

	assign accept    = start && !busy;
	assign room      = fill_q < FILL_W'(MAX_EDGES);
	assign last_edge = (FILL_W'(idx_q) + FILL_W'(1)) == fill_q;

	tcpt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_EDGES)
	) u_edges (
		.clk   (clk),
		.we    (accept && func == FUNC_APPEND && room),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata ({take_coord(ax), take_coord(ay), take_coord(bx), take_coord(by)}),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	assign {e_x0, e_y0, e_x1, e_y1} = rd_data;

	// Edge corners scaled by three so the centroid never has to be divided.
	assign xi3 = times3(e_x0);
	assign yi3 = times3(e_y0);
	assign xj3 = times3(e_x1);
	assign yj3 = times3(e_y1);

	assign straddle = (yi3 < sy_q && yj3 >= sy_q) || (yj3 < sy_q && yi3 >= sy_q);
	assign left_of  = (xi3 <= sx_q) || (xj3 <= sx_q);

	// The shared multiplier forms the left product first, then the right one.
	assign mul_a   = mul_rhs ? opc_q : opa_q;
	assign mul_b   = mul_rhs ? opd_q : opb_q;
	assign product = prod_t'(mul_a) * prod_t'(mul_b);

	// The compare of the previous edge is resolved in the cycle after its
	// second product is registered.
	assign toggle = cmp_pend_q && hit_q && (dpos_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q));
	assign odd_d  = odd_q ^ toggle;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_TEST) begin
					state_d = (fill_q == '0) ? ST_FINISH : ST_FETCH;
				end
			end
			ST_FETCH:  state_d = ST_PREP;
			ST_PREP:   state_d = ST_MULA;
			ST_MULA:   state_d = ST_MULB;
			ST_MULB:   state_d = last_edge ? ST_FINISH : ST_FETCH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		mul_rhs = 1'b0;
		case (state_q)
			ST_IDLE: busy    = 1'b0;
			ST_MULB: mul_rhs = 1'b1;
			default: begin
				busy    = 1'b1;
				mul_rhs = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			idx_q      <= '0;
			odd_q      <= 1'b0;
			cmp_pend_q <= 1'b0;
			done_q     <= 1'b0;
			inside_q   <= 1'b0;
			full_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			done_q     <= 1'b0;
			cmp_pend_q <= (state_q == ST_MULB);
			odd_q      <= odd_d;
			if (accept) begin
				inside_q <= 1'b0;
				full_q   <= 1'b0;
				idx_q    <= '0;
				odd_q    <= 1'b0;
				case (func)
					FUNC_CLEAR: begin
						fill_q <= '0;
						done_q <= 1'b1;
					end
					FUNC_APPEND: begin
						if (room) begin
							fill_q <= fill_q + FILL_W'(1);
						end else begin
							full_q <= 1'b1;
						end
						done_q <= 1'b1;
					end
					FUNC_TEST: begin
						done_q <= 1'b0;
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end
			if (state_q == ST_MULB) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
			if (state_q == ST_FINISH) begin
				done_q   <= 1'b1;
				inside_q <= odd_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sx_q <= sum_t'(take_coord(ax)) + sum_t'(take_coord(bx)) + sum_t'(take_coord(cx));
			sy_q <= sum_t'(take_coord(ay)) + sum_t'(take_coord(by)) + sum_t'(take_coord(cy));
		end
		if (state_q == ST_PREP) begin
			// Both sides of the crossing compare carry a common factor of
			// three, which is dropped from the edge spans.
			opa_q  <= diff_t'(sy_q) - diff_t'(yi3);
			opb_q  <= span_t'(e_x1) - span_t'(e_x0);
			opc_q  <= diff_t'(sx_q) - diff_t'(xi3);
			opd_q  <= span_t'(e_y1) - span_t'(e_y0);
			hit_q  <= straddle && left_of;
			dpos_q <= e_y1 > e_y0;
		end
		if (state_q == ST_MULA) begin
			lhs_q <= product;
		end
		if (state_q == ST_MULB) begin
			rhs_q <= product;
		end
	end

	assign done       = done_q;
	assign inside_res = inside_q;
	assign table_full = full_q;
	assign edge_total = TOTAL_W'(fill_q);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_EDGES))
		else $error("edge count above table size");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(accept) || $past(state_q == ST_FINISH)))
		else $error("result without a finished transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH || state_q == ST_PREP || state_q == ST_MULA ||
		 state_q == ST_MULB) |-> (FILL_W'(idx_q) < fill_q))
		else $error("edge scan beyond stored edges");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && full_q) |-> (fill_q == FILL_W'(MAX_EDGES)))
		else $error("table reported full while not full");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && inside_q) |-> $past(state_q == ST_FINISH))
		else $error("inside result not from a test");
`endif

endmodule
`default_nettype wire
